// ===== hw/rtl/boreg_pkg.sv =====
package boreg_pkg;

   localparam int NUM_BITS    = 32;
   localparam int FREQ_BITS   = 16;
   localparam int NUMER_BITS  = NUM_BITS + FREQ_BITS;
   localparam int MAX_PENDING = 256;
   localparam int PEND_W      = $clog2(MAX_PENDING + 1);
   localparam int MAX_OUT     = 40;
   localparam int OUT_AW      = $clog2(MAX_OUT + 1);
   localparam int DIV_CW      = $clog2(NUMER_BITS);
   localparam int BIT_IW      = $clog2(NUM_BITS);
   localparam int BIT_NW      = $clog2(NUM_BITS + 1);

   localparam logic [NUM_BITS-1:0] TOP_VALUE = NUM_BITS'(1) << (NUM_BITS - 1);

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef logic [NUM_BITS-1:0]  word_type;
   typedef logic [FREQ_BITS-1:0] freq_type;
   typedef logic [PEND_W-1:0]    pend_type;

endpackage

// ===== hw/rtl/binary_output_range_encoder.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    operation, cum_freq, sym_freq, total_freq
// rsp      out        rsp_valid/rsp_ready    out_byte, last, pending_overflow
//
// Encode transaction: two bit-serial divisions through one shared restoring divider,
// an add step, then the renormalization shifts, each settled shift releasing any
// pending ones, before the drain. Finish transaction: a tail search, then the held
// bit and the pending, tail and pad bits are emitted.
// Bytes of one transaction are buffered in a 40-entry memory and drained after the
// item ends (last and pending_overflow are only known then), one byte at a time.
// Reset is synchronous; req_ready is high only when idle, rsp stalls simply hold.
module binary_output_range_encoder import boreg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_operation,
   input  logic [15:0]    req_cum_freq,
   input  logic [15:0]    req_sym_freq,
   input  logic [15:0]    req_total_freq,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last,
   output logic           rsp_pending_overflow
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV1  = 4'd1;
   localparam logic [3:0] S_DIV2  = 4'd2;
   localparam logic [3:0] S_ADD   = 4'd3;
   localparam logic [3:0] S_NORM  = 4'd4;
   localparam logic [3:0] S_PEND  = 4'd5;
   localparam logic [3:0] S_FTAIL = 4'd6;
   localparam logic [3:0] S_FHELD = 4'd7;
   localparam logic [3:0] S_FPEND = 4'd8;
   localparam logic [3:0] S_FLOW  = 4'd9;
   localparam logic [3:0] S_FPAD  = 4'd10;
   localparam logic [3:0] S_END   = 4'd11;
   localparam logic [3:0] S_DRD   = 4'd12;
   localparam logic [3:0] S_DWAIT = 4'd13;

   // coder state
   logic [3:0]  state_ff, state_in;
   word_type    low_ff, low_in;
   logic        carry_ff, carry_in;
   word_type    range_ff, range_in;
   pend_type    pend_ff, pend_in;
   logic        held_ff, held_in;
   logic [1:0]  startup_ff, startup_in;
   logic [7:0]  bshift_ff, bshift_in;
   logic [2:0]  bfill_ff, bfill_in;
   logic        ovf_ff, ovf_in;

   // divider
   logic [NUMER_BITS-1:0] num_ff, num_in;
   freq_type    rem_ff, rem_in;
   word_type    q_ff, q_in;
   logic [DIV_CW-1:0] dcnt_ff, dcnt_in;
   freq_type    t_ff, t_in;
   freq_type    tcf_ff, tcf_in;
   word_type    lo_ff, lo_in;
   word_type    hi_ff, hi_in;

   // finish tail search
   word_type    cand_ff, cand_in;
   logic [NUM_BITS:0] high_ff, high_in;
   word_type    mask_ff, mask_in;
   logic [BIT_IW-1:0] idx_ff, idx_in;
   logic [BIT_NW-1:0] n_ff, n_in;
   logic        fin_ff, fin_in;
   logic        pbit_ff, pbit_in;

   // byte buffer and drain
   logic [7:0]  mem [MAX_OUT];
   logic [OUT_AW-1:0] cnt_ff, cnt_in;
   logic [OUT_AW-1:0] rd_ff, rd_in;
   logic        flag_ff, flag_in;
   logic        rv_ff, rv_in;
   logic        rlast_ff, rlast_in;
   logic [7:0]  rbyte_ff;

   logic        em_v, em_b;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic [FREQ_BITS:0] shifted, diff;
   logic        ge;
   freq_type    rem_nx;
   word_type    q_nx;
   logic [NUM_BITS+1:0] sum;
   logic        settle, item_ok;
   logic [FREQ_BITS:0] cf_sum;
   logic        acc;

   assign req_ready            = (state_ff == S_IDLE);
   assign acc                  = req_valid && req_ready;
   assign rsp_valid            = rv_ff;
   assign rsp_out_byte         = rbyte_ff;
   assign rsp_last             = rlast_ff;
   assign rsp_pending_overflow = flag_ff;

   // one restoring division step
   assign shifted = {rem_ff, num_ff[NUMER_BITS-1]};
   assign diff    = shifted - {1'b0, t_ff};
   assign ge      = (shifted >= {1'b0, t_ff});
   assign rem_nx  = ge ? diff[FREQ_BITS-1:0] : shifted[FREQ_BITS-1:0];
   assign q_nx    = {q_ff[NUM_BITS-2:0], ge};

   assign sum    = {2'b00, low_ff} + {2'b00, lo_ff} + {1'b0, carry_ff, NUM_BITS'(0)};
   assign settle = !low_ff[NUM_BITS-1] || carry_ff;
   assign cf_sum = {1'b0, req_cum_freq} + {1'b0, req_sym_freq};
   assign item_ok = (req_total_freq != '0) && (req_sym_freq != '0)
                    && (cf_sum <= {1'b0, req_total_freq});

   always_comb begin
      state_in   = state_ff;
      low_in     = low_ff;
      carry_in   = carry_ff;
      range_in   = range_ff;
      pend_in    = pend_ff;
      held_in    = held_ff;
      startup_in = startup_ff;
      ovf_in     = ovf_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      q_in       = q_ff;
      dcnt_in    = dcnt_ff;
      t_in       = t_ff;
      tcf_in     = tcf_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      cand_in    = cand_ff;
      high_in    = high_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      fin_in     = fin_ff;
      pbit_in    = pbit_ff;
      rd_in      = rd_ff;
      flag_in    = flag_ff;
      rv_in      = rv_ff;
      rlast_in   = rlast_ff;
      em_v       = 1'b0;
      em_b       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_operation == OP_FINISH) begin
                  fin_in   = 1'b1;
                  cand_in  = low_ff;
                  high_in  = {1'b0, low_ff} + {1'b0, range_ff};
                  mask_in  = NUM_BITS'(1);
                  idx_in   = '0;
                  n_in     = BIT_NW'(NUM_BITS);
                  state_in = S_FTAIL;
               end else if (item_ok) begin
                  fin_in   = 1'b0;
                  t_in     = req_total_freq;
                  tcf_in   = req_total_freq - req_cum_freq - req_sym_freq;
                  num_in   = NUMER_BITS'(range_ff) *
                             NUMER_BITS'(req_total_freq - req_cum_freq);
                  rem_in   = '0;
                  q_in     = '0;
                  dcnt_in  = '0;
                  state_in = S_DIV1;
               end
            end
         end
         S_DIV1, S_DIV2: begin
            num_in  = num_ff << 1;
            rem_in  = rem_nx;
            q_in    = q_nx;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_CW'(NUMER_BITS - 1)) begin
               dcnt_in = '0;
               rem_in  = '0;
               q_in    = '0;
               if (state_ff == S_DIV1) begin
                  lo_in    = range_ff - q_nx;
                  num_in   = NUMER_BITS'(range_ff) * NUMER_BITS'(tcf_ff);
                  state_in = S_DIV2;
               end else begin
                  hi_in    = range_ff - q_nx;
                  state_in = S_ADD;
               end
            end
         end
         S_ADD: begin
            low_in   = sum[NUM_BITS-1:0];
            carry_in = sum[NUM_BITS];
            range_in = hi_ff - lo_ff;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (range_ff >= TOP_VALUE) begin
               state_in = S_END;
            end else begin
               range_in = range_ff << 1;
               low_in   = low_ff << 1;
               if (settle) begin
                  em_v       = (startup_ff == 2'd0);
                  em_b       = held_ff ^ carry_ff;
                  pbit_in    = !carry_ff;
                  held_in    = low_ff[NUM_BITS-1];
                  startup_in = (startup_ff != 2'd0) ? startup_ff - 1'b1 : 2'd0;
                  carry_in   = 1'b0;
                  if (pend_ff != '0) state_in = S_PEND;
               end else if (pend_ff < PEND_W'(MAX_PENDING)) begin
                  pend_in = pend_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         S_PEND, S_FPEND: begin
            em_v    = 1'b1;
            em_b    = pbit_ff;
            pend_in = pend_ff - 1'b1;
            if (pend_ff == PEND_W'(1))
               state_in = (state_ff == S_PEND) ? S_NORM : S_FLOW;
         end
         S_FTAIL: begin
            // widen the tail while it stays below the interval top
            if ({1'b0, cand_ff | mask_ff} < high_ff) begin
               cand_in = cand_ff | mask_ff;
               n_in    = n_ff - 1'b1;
            end
            mask_in = {mask_ff[NUM_BITS-2:0], 1'b1};
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == BIT_IW'(NUM_BITS - 1)) state_in = S_FHELD;
         end
         S_FHELD: begin
            low_in  = cand_ff;
            pbit_in = !carry_ff;
            em_v    = (startup_ff == 2'd0) && ((n_ff != '0) || !(held_ff ^ carry_ff));
            em_b    = held_ff ^ carry_ff;
            if ((n_ff == '0) && !carry_ff) begin
               pend_in  = '0;
               state_in = S_FLOW;
            end else begin
               state_in = (pend_ff != '0) ? S_FPEND : S_FLOW;
            end
         end
         S_FLOW: begin
            if (n_ff == '0) begin
               state_in = S_FPAD;
            end else begin
               em_v   = 1'b1;
               em_b   = low_ff[NUM_BITS-1];
               low_in = low_ff << 1;
               n_in   = n_ff - 1'b1;
            end
         end
         S_FPAD: begin
            if (bfill_ff == 3'd0) begin
               state_in = S_END;
            end else begin
               em_v = 1'b1;
               em_b = 1'b1;
            end
         end
         S_END: begin
            flag_in = ovf_ff;
            rd_in   = '0;
            if (fin_ff) begin
               low_in     = '0;
               carry_in   = 1'b0;
               range_in   = TOP_VALUE;
               pend_in    = '0;
               held_in    = 1'b0;
               startup_in = 2'd2;
               ovf_in     = 1'b0;
            end
            state_in = (cnt_ff == '0) ? S_IDLE : S_DRD;
         end
         S_DRD: begin
            rv_in    = 1'b1;
            rlast_in = (rd_ff == cnt_ff - 1'b1);
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (rsp_ready) begin
               rv_in    = 1'b0;
               rd_in    = rd_ff + 1'b1;
               state_in = rlast_ff ? S_IDLE : S_DRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // bit packer, MSB first
   always_comb begin
      bshift_in = bshift_ff;
      bfill_in  = bfill_ff;
      cnt_in    = cnt_ff;
      wr_en     = 1'b0;
      wr_data   = {bshift_ff[6:0], em_b};
      if (acc) cnt_in = '0;
      if (em_v) begin
         if (bfill_ff == 3'd7) begin
            bshift_in = '0;
            bfill_in  = '0;
            if (cnt_ff < OUT_AW'(MAX_OUT)) begin
               wr_en  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end else begin
            bshift_in = wr_data;
            bfill_in  = bfill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         low_ff     <= '0;
         carry_ff   <= 1'b0;
         range_ff   <= TOP_VALUE;
         pend_ff    <= '0;
         held_ff    <= 1'b0;
         startup_ff <= 2'd2;
         bshift_ff  <= '0;
         bfill_ff   <= '0;
         ovf_ff     <= 1'b0;
         cnt_ff     <= '0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         low_ff     <= low_in;
         carry_ff   <= carry_in;
         range_ff   <= range_in;
         pend_ff    <= pend_in;
         held_ff    <= held_in;
         startup_ff <= startup_in;
         bshift_ff  <= bshift_in;
         bfill_ff   <= bfill_in;
         ovf_ff     <= ovf_in;
         cnt_ff     <= cnt_in;
         rv_ff      <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      dcnt_ff  <= dcnt_in;
      t_ff     <= t_in;
      tcf_ff   <= tcf_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      cand_ff  <= cand_in;
      high_ff  <= high_in;
      mask_ff  <= mask_in;
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      fin_ff   <= fin_in;
      pbit_ff  <= pbit_in;
      rd_ff    <= rd_in;
      flag_ff  <= flag_in;
      rlast_ff <= rlast_in;
   end

   // byte buffer: one write port, registered read into the output stage
   always_ff @(posedge clock) begin
      if (wr_en) mem[cnt_ff[OUT_AW-1:0]] <= wr_data;
      if (state_ff == S_DRD) rbyte_ff <= mem[rd_ff];
   end

`ifndef NO_ASSERTIONS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready)
      else $error("not idle after final byte");

   a_norm_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> range_ff[NUM_BITS-1])
      else $error("range not normalized while idle");
`endif

endmodule
